// File: sv/obt_pkg.sv
// Shared types and constants for the order book table.
// Holds the table depth, derived widths, op and status codes, the entry layout,
// the controller state type and the controller/datapath command and status structs.
package obt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int RMV_W       = 7;
   localparam int RMV_MAX     = 127;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_MODIFY  = 3'd1,
      OP_CANCEL  = 3'd2,
      OP_EXECUTE = 3'd3,
      OP_PARTIAL = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] order_id;
      logic [31:0] quantity;
      logic [31:0] price;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

// File: sv/order_book_table.sv
// Top level of the order book table: joins obt_ctrl and obt_datapath
// and packs the stream channels; depends on obt_pkg.
//
//  channel | direction | tuser         | tdata
//  req_    | in        | op [2:0]      | order_id, amount, limit_price (96 bits)
//  rsp_    | out       | status [1:0]  | removed_count, remaining_quantity (40 bits)
//
// Add and unused ops go from accept to the finish state, which registers the result
// and returns to idle. Modify, cancel, execute and partial execute scan one entry
// per cycle through the memory read port with compaction writes on the write port,
// then register the result in the finish state; a new item is taken only in idle.
// Reset clears the entry count; the entry memory needs no clearing.
// A new item is accepted while a result waits; the next result holds until taken.
module order_book_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // order_id [31:0], amount [63:32], limit_price [95:64]
   input  logic [2:0]  req_tuser,  // op [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // removed_count [6:0], remaining_quantity [38:7], zero [39]
   output logic [1:0]  rsp_tuser   // status [1:0]
);

   obt_pkg::dp_cmd_type  cmd;
   obt_pkg::dp_stat_type stat;
   logic [6:0]           removed_count;
   logic [31:0]          remaining_quantity;

   obt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   obt_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_op                 (req_tuser),
      .req_order_id           (req_tdata[31:0]),
      .req_amount             (req_tdata[63:32]),
      .req_limit_price        (req_tdata[95:64]),
      .rsp_tready             (rsp_tready),
      .stat                   (stat),
      .rsp_tvalid             (rsp_tvalid),
      .rsp_status             (rsp_tuser),
      .rsp_removed_count      (removed_count),
      .rsp_remaining_quantity (remaining_quantity)
   );

   assign rsp_tdata = {1'b0, remaining_quantity, removed_count};

endmodule

// File: sv/obt_ctrl.sv
// Controller for the order book table.
// Sequences accept, table scan and result hand-off; depends on obt_pkg.
module obt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [2:0]          req_op,
   input  obt_pkg::dp_stat_type stat,
   output logic                req_tready,
   output obt_pkg::dp_cmd_type cmd
);

   obt_pkg::state_type state_ff, state_in;
   logic               scan_op;

   always_comb begin
      case (obt_pkg::op_type'(req_op))
         obt_pkg::OP_MODIFY,
         obt_pkg::OP_CANCEL,
         obt_pkg::OP_EXECUTE,
         obt_pkg::OP_PARTIAL: scan_op = 1'b1;
         default:             scan_op = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         obt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = scan_op ? obt_pkg::S_SCAN : obt_pkg::S_FINISH;
            end
         end
         obt_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               state_in = obt_pkg::S_FINISH;
            end
         end
         obt_pkg::S_FINISH: begin
            if (stat.out_free) begin
               state_in = obt_pkg::S_IDLE;
            end
         end
         default: state_in = obt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         obt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         obt_pkg::S_SCAN:   cmd.scan   = 1'b1;
         obt_pkg::S_FINISH: cmd.finish = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= obt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan completion hands over to the result step
   a_scan_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == obt_pkg::S_SCAN && stat.scan_done) |=> state_ff == obt_pkg::S_FINISH)
      else $error("scan completion did not reach result step");

endmodule

// File: sv/obt_datapath.sv
// Datapath for the order book table: entry memory, scan and compaction,
// entry count and result register; depends on obt_pkg.
module obt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  obt_pkg::dp_cmd_type  cmd,
   input  logic [2:0]           req_op,
   input  logic [31:0]          req_order_id,
   input  logic [31:0]          req_amount,
   input  logic [31:0]          req_limit_price,
   input  logic                 rsp_tready,
   output obt_pkg::dp_stat_type stat,
   output logic                 rsp_tvalid,
   output logic [1:0]           rsp_status,
   output logic [6:0]           rsp_removed_count,
   output logic [31:0]          rsp_remaining_quantity
);

   obt_pkg::entry_type mem [obt_pkg::TABLE_DEPTH];

   obt_pkg::op_type    op_ff;
   logic [31:0]        id_ff, amt_ff, price_ff;
   logic [obt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [obt_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [obt_pkg::CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [obt_pkg::CNT_W-1:0] removed_ff, removed_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               found_ff, found_in;
   logic [31:0]        remain_ff, remain_in;
   obt_pkg::entry_type rd_q_ff;

   logic               rsp_vld_ff, rsp_vld_in;
   logic [1:0]         rsp_status_ff;
   logic [6:0]         rsp_removed_ff;
   logic [31:0]        rsp_remain_ff;

   logic               rd_en;
   logic               we;
   logic [obt_pkg::ADDR_W-1:0] wr_addr;
   obt_pkg::entry_type wr_data;
   logic               full;
   logic               fire;
   logic               match, first, keep, bump;
   logic [31:0]        new_qty;
   logic [1:0]         res_status;
   logic [6:0]         res_removed;
   logic [31:0]        res_remain;

   assign full = count_ff >= obt_pkg::CNT_W'(obt_pkg::TABLE_DEPTH);
   assign fire = cmd.finish;
   assign rd_en = cmd.scan && (rd_idx_ff < count_ff);

   assign stat.scan_done = (rd_idx_ff == count_ff) && !rd_vld_ff;
   assign stat.out_free  = !rsp_vld_ff || rsp_tready;

   // decide keep, drop or rewrite for the entry just read
   always_comb begin
      match   = rd_vld_ff && (rd_q_ff.order_id == id_ff);
      first   = match && !found_ff;
      keep    = 1'b1;
      bump    = 1'b0;
      new_qty = rd_q_ff.quantity;
      remain_in = remain_ff;
      case (op_ff)
         obt_pkg::OP_MODIFY: begin
            if (first) begin
               new_qty   = amt_ff;
               remain_in = amt_ff;
            end
         end
         obt_pkg::OP_CANCEL: begin
            if (match) begin
               keep = 1'b0;
               bump = 1'b1;
            end
         end
         obt_pkg::OP_EXECUTE: begin
            if (first) begin
               keep = 1'b0;
               bump = 1'b1;
            end
         end
         obt_pkg::OP_PARTIAL: begin
            if (first) begin
               if (amt_ff < rd_q_ff.quantity) begin
                  new_qty   = rd_q_ff.quantity - amt_ff;
                  remain_in = rd_q_ff.quantity - amt_ff;
               end else begin
                  keep = 1'b0;
                  bump = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      we      = 1'b0;
      wr_addr = wr_idx_ff[obt_pkg::ADDR_W-1:0];
      wr_data = '{order_id: rd_q_ff.order_id, quantity: new_qty, price: rd_q_ff.price};
      if (rd_vld_ff && keep) begin
         we = 1'b1;
      end else if (fire && op_ff == obt_pkg::OP_ADD && !full) begin
         we      = 1'b1;
         wr_addr = count_ff[obt_pkg::ADDR_W-1:0];
         wr_data = '{order_id: id_ff, quantity: amt_ff, price: price_ff};
      end
   end

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      rd_vld_in  = rd_en;
      count_in   = count_ff;
      if (rd_en) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (rd_vld_ff) begin
         found_in = found_ff | match;
         if (keep) begin
            wr_idx_in = wr_idx_ff + 1'b1;
         end
         if (bump) begin
            removed_in = removed_ff + 1'b1;
         end
      end
      if (cmd.load) begin
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         removed_in = '0;
         found_in   = 1'b0;
         rd_vld_in  = 1'b0;
      end
      if (fire) begin
         case (op_ff)
            obt_pkg::OP_ADD: begin
               if (!full) begin
                  count_in = count_ff + 1'b1;
               end
            end
            obt_pkg::OP_MODIFY,
            obt_pkg::OP_CANCEL,
            obt_pkg::OP_EXECUTE,
            obt_pkg::OP_PARTIAL: count_in = wr_idx_ff;
            default: ;
         endcase
      end
   end

   // form the result
   always_comb begin
      res_status = obt_pkg::ST_DONE;
      res_remain = '0;
      if (32'(removed_ff) > 32'(obt_pkg::RMV_MAX)) begin
         res_removed = obt_pkg::RMV_W'(obt_pkg::RMV_MAX);
      end else begin
         res_removed = obt_pkg::RMV_W'(removed_ff);
      end
      case (op_ff)
         obt_pkg::OP_ADD: begin
            if (full) begin
               res_status = obt_pkg::ST_FULL;
            end else begin
               res_remain = amt_ff;
            end
         end
         obt_pkg::OP_MODIFY,
         obt_pkg::OP_CANCEL,
         obt_pkg::OP_EXECUTE,
         obt_pkg::OP_PARTIAL: begin
            if (found_ff) begin
               res_remain = remain_ff;
            end else begin
               res_status = obt_pkg::ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   assign rsp_vld_in = fire ? 1'b1 : (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_idx_ff[obt_pkg::ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff    <= req_order_id;
         amt_ff   <= req_amount;
         price_ff <= req_limit_price;
      end
      remain_ff <= cmd.load ? 32'd0 : remain_in;
      if (fire) begin
         rsp_status_ff  <= res_status;
         rsp_removed_ff <= res_removed;
         rsp_remain_ff  <= res_remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= obt_pkg::OP_ADD;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         removed_ff <= '0;
         found_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            op_ff <= obt_pkg::op_type'(req_op);
         end
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         removed_ff <= removed_in;
         found_ff   <= found_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid             = rsp_vld_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_removed_count      = rsp_removed_ff;
   assign rsp_remaining_quantity = rsp_remain_ff;

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= rd_idx_ff)
      else $error("compaction write index ran ahead of read index");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= obt_pkg::CNT_W'(obt_pkg::TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> count_ff == $past(count_ff))
      else $error("entry count changed outside result step");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for order_book_table: drives order requests on the req_ stream
// and checks every rsp_ item against an in-bench model of the order table.
// Depends on obt_pkg and the order_book_table RTL.
module tb_top;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   localparam int ITEM_TARGET = 900;
   localparam int CALM_TAIL   = 120;
   localparam int CHOKE_AT    = 350;
   localparam int CHOKE_LEN   = 400;
   localparam int SHOW_MAX    = 100;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] order_id;
      logic [31:0] amount;
      logic [31:0] limit_price;
   } order_req_type;

   typedef struct {
      obt_pkg::status_type status;
      logic [6:0]  removed;
      logic [31:0] remaining;
   } fill_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // book 0 mirrors the table while stimulus is built, book 1 predicts the results
   logic [31:0] book_id  [0:1][0:obt_pkg::TABLE_DEPTH-1];
   logic [31:0] book_qty [0:1][0:obt_pkg::TABLE_DEPTH-1];
   int          book_len [0:1] = '{0, 0};

   order_req_type   pending[$];
   fill_report_type reports_due[$];
   order_req_type   on_wire;
   logic [31:0]  id_pool [0:7];
   logic         calm = 1'b0;
   int           send_gap = 0;
   int           rsp_gap = 0;
   int           choke_left = 0;
   int           taken_n = 0;
   int           rsp_n = 0;
   int           error_count = 0;

   order_book_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int oldest_slot(input int s, input logic [31:0] id);
      int pos;
      pos = -1;
      for (int i = 0; i < book_len[s]; i++)
         if (pos < 0 && book_id[s][i] == id) pos = i;
      return pos;
   endfunction

   function automatic void drop_slot(input int s, input int pos);
      for (int i = pos; i + 1 < book_len[s]; i++) begin
         book_id[s][i]  = book_id[s][i+1];
         book_qty[s][i] = book_qty[s][i+1];
      end
      book_len[s] = book_len[s] - 1;
   endfunction

   function automatic fill_report_type book_apply(input int s, input order_req_type o);
      fill_report_type v;
      int pos;
      int w;
      int hits;
      v.status    = obt_pkg::ST_DONE;
      v.removed   = '0;
      v.remaining = '0;
      pos  = oldest_slot(s, o.order_id);
      hits = 0;
      case (o.op)
         obt_pkg::OP_ADD: begin
            if (book_len[s] >= obt_pkg::TABLE_DEPTH) begin
               v.status = obt_pkg::ST_FULL;
            end else begin
               book_id[s][book_len[s]]  = o.order_id;
               book_qty[s][book_len[s]] = o.amount;
               book_len[s] = book_len[s] + 1;
               v.remaining = o.amount;
            end
         end
         obt_pkg::OP_MODIFY: begin
            if (pos < 0) begin
               v.status = obt_pkg::ST_NOT_FOUND;
            end else begin
               book_qty[s][pos] = o.amount;
               v.remaining = o.amount;
            end
         end
         obt_pkg::OP_CANCEL: begin
            w = 0;
            for (int i = 0; i < book_len[s]; i++) begin
               if (book_id[s][i] == o.order_id) begin
                  hits++;
               end else begin
                  book_id[s][w]  = book_id[s][i];
                  book_qty[s][w] = book_qty[s][i];
                  w++;
               end
            end
            book_len[s] = w;
            if (hits == 0) v.status = obt_pkg::ST_NOT_FOUND;
            v.removed = (hits > obt_pkg::RMV_MAX) ? 7'(obt_pkg::RMV_MAX) : 7'(hits);
         end
         obt_pkg::OP_EXECUTE: begin
            if (pos < 0) begin
               v.status = obt_pkg::ST_NOT_FOUND;
            end else begin
               drop_slot(s, pos);
               v.removed = 7'd1;
            end
         end
         obt_pkg::OP_PARTIAL: begin
            if (pos < 0) begin
               v.status = obt_pkg::ST_NOT_FOUND;
            end else if (o.amount < book_qty[s][pos]) begin
               book_qty[s][pos] = book_qty[s][pos] - o.amount;
               v.remaining = book_qty[s][pos];
            end else begin
               drop_slot(s, pos);
               v.removed = 7'd1;
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic order_req_type make_order(input logic [2:0] op, input logic [31:0] id,
                                                input logic [31:0] amt,
                                                input logic [31:0] price);
      order_req_type o;
      o.op          = op;
      o.order_id    = id;
      o.amount      = amt;
      o.limit_price = price;
      return o;
   endfunction

   function automatic void queue_order(input order_req_type o);
      void'(book_apply(0, o));
      pending.insert(pending.size(), o);
   endfunction

   function automatic logic [31:0] pick_id();
      if (book_len[0] > 0 && $urandom_range(0, 9) < 8)
         return book_id[0][$urandom_range(0, book_len[0] - 1)];
      if ($urandom_range(0, 1) == 0)
         return id_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_amount();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1000);
         1: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_random(input int add_w);
      logic [31:0] id;
      logic [31:0] q;
      int pos;
      int r;
      r  = $urandom_range(0, 99);
      id = pick_id();
      if (r < add_w) begin
         queue_order(make_order(obt_pkg::OP_ADD, id, pick_amount(), $urandom()));
      end else if (r < add_w + 3) begin
         queue_order(make_order(3'($urandom_range(OP_RSVD5, OP_RSVD7)), $urandom(),
                                $urandom(), $urandom()));
      end else begin
         case ($urandom_range(0, 3))
            0: queue_order(make_order(obt_pkg::OP_MODIFY, id, pick_amount(), $urandom()));
            1: queue_order(make_order(obt_pkg::OP_CANCEL, id, $urandom(), $urandom()));
            2: queue_order(make_order(obt_pkg::OP_EXECUTE, id, $urandom(), $urandom()));
            default: begin
               pos = oldest_slot(0, id);
               q   = (pos < 0) ? $urandom() : book_qty[0][pos];
               case ($urandom_range(0, 2))
                  0: q = (q == 0) ? 32'h0 : 32'($urandom_range(q - 1, 0));
                  1: ;
                  default: q = pick_amount();
               endcase
               queue_order(make_order(obt_pkg::OP_PARTIAL, id, q, $urandom()));
            end
         endcase
      end
   endfunction

   function automatic void queue_flood();
      logic [31:0] id;
      while (book_len[0] > 0)
         queue_order(make_order(obt_pkg::OP_CANCEL, book_id[0][0], $urandom(), $urandom()));
      id = $urandom();
      repeat (obt_pkg::TABLE_DEPTH + 1)
         queue_order(make_order(obt_pkg::OP_ADD, id, $urandom(), $urandom()));
      queue_order(make_order(obt_pkg::OP_CANCEL, id, $urandom(), $urandom()));
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            reports_due.insert(reports_due.size(), book_apply(1, on_wire));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
               on_wire = pending.pop_front();
               req_tdata  <= {on_wire.limit_price, on_wire.amount, on_wire.order_id};
               req_tuser  <= on_wire.op;
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         calm <= (pending.size() < CALM_TAIL);
      end
   end

   // long receiver hold-off once the pipe is well under way
   always @(posedge clock) begin
      if (reset) begin
         taken_n    <= 0;
         choke_left <= 0;
      end else begin
         if (req_tvalid && req_tready) taken_n <= taken_n + 1;
         if (req_tvalid && req_tready && taken_n == CHOKE_AT)
            choke_left <= CHOKE_LEN;
         else if (choke_left != 0)
            choke_left <= choke_left - 1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      fill_report_type exp_r;
      logic [6:0]   got_removed;
      logic [31:0]  got_remaining;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_removed   = rsp_tdata[6:0];
            got_remaining = rsp_tdata[38:7];
            rsp_n++;
            if (reports_due.size() == 0) begin
               error_count++;
               if (error_count <= SHOW_MAX)
                  $display("%0t: item %0d unexpected: status %0d removed %0d remaining %0h",
                           $time, rsp_n, rsp_tuser, got_removed, got_remaining);
            end else begin
               exp_r = reports_due.pop_front();
               if (rsp_tuser !== exp_r.status || got_removed !== exp_r.removed ||
                   got_remaining !== exp_r.remaining) begin
                  error_count++;
                  if (error_count <= SHOW_MAX)
                     $display("%0t: item %0d expected status %0d removed %0d remaining %0h, %s",
                              $time, rsp_n, exp_r.status, exp_r.removed, exp_r.remaining,
                              $sformatf("got status %0d removed %0d remaining %0h",
                                        rsp_tuser, got_removed, got_remaining));
               end
            end
         end
         if (choke_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_len;
      for (int i = 0; i < 8; i++) id_pool[i] = $urandom();

      // directed: empty table, field extremes, duplicates, compaction, unused ops
      queue_order(make_order(obt_pkg::OP_EXECUTE, 32'h0, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_MODIFY, 32'hFFFF_FFFF, 32'h1, 32'h0));
      queue_order(make_order(obt_pkg::OP_CANCEL, 32'h0, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_PARTIAL, 32'h0, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h0, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h0, 32'h5, 32'h1234));
      queue_order(make_order(obt_pkg::OP_MODIFY, 32'h0, 32'd100, 32'h0));
      queue_order(make_order(obt_pkg::OP_PARTIAL, 32'hFFFF_FFFF, 32'h1, 32'h0));
      queue_order(make_order(obt_pkg::OP_PARTIAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
      queue_order(make_order(obt_pkg::OP_PARTIAL, 32'h0, 32'd100, 32'h0));
      queue_order(make_order(obt_pkg::OP_EXECUTE, 32'h0, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h7, 32'h1, 32'h1));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h8, 32'h2, 32'h2));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h7, 32'h3, 32'h3));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h9, 32'h4, 32'h4));
      queue_order(make_order(obt_pkg::OP_ADD, 32'h7, 32'h5, 32'h5));
      queue_order(make_order(obt_pkg::OP_EXECUTE, 32'h8, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_MODIFY, 32'h9, 32'hAAAA_5555, 32'h0));
      queue_order(make_order(obt_pkg::OP_CANCEL, 32'h7, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_PARTIAL, 32'h9, 32'hAAAA_5554, 32'h0));
      queue_order(make_order(OP_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_order(make_order(OP_RSVD6, 32'h9, 32'h1, 32'h0));
      queue_order(make_order(OP_RSVD7, 32'h9, 32'h0, 32'h0));
      queue_order(make_order(obt_pkg::OP_EXECUTE, 32'h9, 32'h0, 32'h0));

      queue_flood();
      while (pending.size() < ITEM_TARGET) begin
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 7))
            0: repeat (obt_pkg::TABLE_DEPTH + 2)
                  queue_order(make_order(obt_pkg::OP_ADD, pick_id(), pick_amount(),
                                         $urandom()));
            1: begin
               id_pool[$urandom_range(0, 7)] = $urandom();
               repeat (phase_len) queue_random(65);
            end
            2: repeat (phase_len) queue_random(20);
            3: if ($urandom_range(0, 3) == 0) queue_flood();
            default: repeat (phase_len) queue_random(45);
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
sv/obt_pkg.sv
sv/obt_ctrl.sv
sv/obt_datapath.sv
sv/order_book_table.sv
bench/tb_top.sv
